// ===== rtl/dfd_pkg.sv =====
// dfd_pkg: shared widths, constants, types and the divider step function
// for the depth foreground detector. No dependencies.

package dfd_pkg;

    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int DEPTH_W = 16;
    localparam int SHADE_W = 8;

    // averaging window in samples; foreground needs more than 7/8 of it
    localparam int SAMPLE_WINDOW  = 32;
    localparam int FG_COUNT_LIMIT = (SAMPLE_WINDOW * 7) / 8;

    // pipelined restoring divider: quotient bits resolved per stage
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STAGES    = SUM_W / DIV_STEP_BITS;
    localparam int REM_W         = CNT_W;

    // shade = diff*255/8000, saturated; rounded-up reciprocal of 125 after >>6
    localparam int SHADE_SCALE = 255;
    localparam int SHADE_RANGE = 8000;
    localparam int SHADE_MAX   = 255;
    localparam int SHADE_X_W   = DEPTH_W + 8;
    localparam int SHADE_Y_LSB = 6;
    localparam int SHADE_Y_W   = 15;
    localparam int SHADE_RECIP = 33555;
    localparam int RECIP_W     = 16;
    localparam int SHADE_SHIFT = 22;
    localparam int PROD_W      = SHADE_Y_W + RECIP_W;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [SUM_W-1:0]   num;
        logic [CNT_W-1:0]   cnt;
        logic [DEPTH_W-1:0] bg;
    } div_stage_t;

    typedef struct packed {
        logic [SUM_W-1:0]   quot;
        logic [CNT_W-1:0]   cnt;
        logic [DEPTH_W-1:0] bg;
    } quot_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] avg;
        logic               fg;
        logic [DEPTH_W-1:0] diff;
        logic [SHADE_W-1:0] shade;
    } result_t;

    // one stage worth of restoring division steps; quotient bits shift in at the bottom
    function automatic div_stage_t div_step(div_stage_t s);
        div_stage_t       o;
        logic [REM_W:0]   r;
        int               i;
        o = s;
        for (i = 0; i < DIV_STEP_BITS; i++)
        begin
            r = {o.rem, o.num[SUM_W-1]};
            o.num = {o.num[SUM_W-2:0], 1'b0};
            if (r >= {1'b0, o.cnt})
            begin
                r = r - {1'b0, o.cnt};
                o.num[0] = 1'b1;
            end
            o.rem = r[REM_W-1:0];
        end
        return o;
    endfunction

endpackage

// ===== rtl/dfd_if.sv =====
// dfd_if: valid/ready channel interfaces for pixel input and result output.
// Depends on dfd_pkg for field widths.

interface dfd_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [dfd_pkg::SUM_W-1:0]   depth_sum;
    logic [dfd_pkg::CNT_W-1:0]   sample_count;
    logic [dfd_pkg::DEPTH_W-1:0] background_depth;

    modport source (output valid, depth_sum, sample_count, background_depth, input ready);
    modport sink   (input valid, depth_sum, sample_count, background_depth, output ready);
endinterface

interface dfd_result_if;
    logic                        valid;
    logic                        ready;
    logic [dfd_pkg::DEPTH_W-1:0] average_depth;
    logic                        is_foreground;
    logic [dfd_pkg::DEPTH_W-1:0] depth_difference;
    logic [dfd_pkg::SHADE_W-1:0] difference_shade;

    modport source (output valid, average_depth, is_foreground, depth_difference,
                    difference_shade, input ready);
    modport sink   (input valid, average_depth, is_foreground, depth_difference,
                    difference_shade, output ready);
endinterface

// ===== rtl/dfd_divider.sv =====
// dfd_divider: pipelined restoring divider, depth_sum / sample_count,
// a few quotient bits per stage. Depends on dfd_pkg and dfd_if.

module dfd_divider
(
    input  logic               clk,
    input  logic               rst_n,
    dfd_pixel_if.sink          pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output dfd_pkg::quot_t     out_data
);

    localparam int N = dfd_pkg::DIV_STAGES;

    dfd_pkg::div_stage_t stage_reg  [N];
    dfd_pkg::div_stage_t stage_in   [N];
    dfd_pkg::div_stage_t stage_next [N];
    logic [N-1:0]        valid_reg;
    logic [N-1:0]        valid_in;
    logic [N:0]          rdy;

    assign rdy[N] = out_ready;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                always_comb
                begin
                    stage_in[g].rem = '0;
                    stage_in[g].num = pixel.depth_sum;
                    stage_in[g].cnt = pixel.sample_count;
                    stage_in[g].bg  = pixel.background_depth;
                end
                assign valid_in[g] = pixel.valid;
            end
            else
            begin : g_rest
                assign stage_in[g] = stage_reg[g-1];
                assign valid_in[g] = valid_reg[g-1];
            end

            assign rdy[g]        = !valid_reg[g] || rdy[g+1];
            assign stage_next[g] = dfd_pkg::div_step(stage_in[g]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (rdy[g])
                begin
                    valid_reg[g] <= valid_in[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[g] && valid_in[g])
                begin
                    stage_reg[g] <= stage_next[g];
                end
            end
        end
    endgenerate

    assign pixel.ready   = rdy[0];
    assign out_valid     = valid_reg[N-1];
    assign out_data.quot = stage_reg[N-1].num;
    assign out_data.cnt  = stage_reg[N-1].cnt;
    assign out_data.bg   = stage_reg[N-1].bg;

endmodule

// ===== rtl/dfd_classify.sv =====
// dfd_classify: saturating average, background compare and shade scaling,
// three register stages ending in the output register. Depends on dfd_pkg, dfd_if.

module dfd_classify
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dfd_pkg::DEPTH_W-1:0] diff_threshold,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dfd_pkg::quot_t              in_data,
    dfd_result_if.source                result
);

    localparam int DW = dfd_pkg::DEPTH_W;
    localparam int CW = dfd_pkg::CNT_W;

    typedef struct packed {
        logic [DW-1:0]                  avg;
        logic                           fg;
        logic [DW-1:0]                  diff;
        logic                           sat;
        logic [dfd_pkg::SHADE_Y_W-1:0]  y;
    } cmp_t;

    typedef struct packed {
        logic [DW-1:0]                  avg;
        logic                           fg;
        logic [DW-1:0]                  diff;
        logic                           sat;
        logic [dfd_pkg::PROD_W-1:0]     prod;
    } scale_t;

    cmp_t              cmp_reg, cmp_next;
    scale_t            scl_reg, scl_next;
    dfd_pkg::result_t  res_reg, res_next;
    logic              cmp_valid_reg, scl_valid_reg, res_valid_reg;
    logic              cmp_rdy, scl_rdy, res_rdy;

    logic [DW-1:0]                  avg;
    logic [DW-1:0]                  diff_abs;
    logic [dfd_pkg::SHADE_X_W-1:0]  x;

    assign res_rdy  = !res_valid_reg || result.ready;
    assign scl_rdy  = !scl_valid_reg || res_rdy;
    assign cmp_rdy  = !cmp_valid_reg || scl_rdy;
    assign in_ready = cmp_rdy;

    // stage 1: saturate, absolute difference, foreground decision
    always_comb
    begin
        if (in_data.cnt == '0)
        begin
            avg = '0;
        end
        else if (|in_data.quot[dfd_pkg::SUM_W-1:DW])
        begin
            avg = '1;
        end
        else
        begin
            avg = in_data.quot[DW-1:0];
        end

        if (avg >= in_data.bg)
        begin
            diff_abs = avg - in_data.bg;
        end
        else
        begin
            diff_abs = in_data.bg - avg;
        end

        // diff*255 as shift and subtract
        x = {diff_abs, 8'b0} - {8'b0, diff_abs};

        cmp_next.avg  = avg;
        cmp_next.fg   = (avg != '0) && (in_data.cnt > CW'(dfd_pkg::FG_COUNT_LIMIT))
                        && (diff_abs > diff_threshold);
        cmp_next.diff = cmp_next.fg ? diff_abs : '0;
        cmp_next.sat  = diff_abs >= DW'(dfd_pkg::SHADE_RANGE);
        cmp_next.y    = x[dfd_pkg::SHADE_Y_LSB +: dfd_pkg::SHADE_Y_W];
    end

    // stage 2: reciprocal multiply for /125
    always_comb
    begin
        scl_next.avg  = cmp_reg.avg;
        scl_next.fg   = cmp_reg.fg;
        scl_next.diff = cmp_reg.diff;
        scl_next.sat  = cmp_reg.sat;
        scl_next.prod = dfd_pkg::PROD_W'(cmp_reg.y)
                        * dfd_pkg::PROD_W'(dfd_pkg::SHADE_RECIP);
    end

    // stage 3: shade select into the output register
    always_comb
    begin
        res_next.avg  = scl_reg.avg;
        res_next.fg   = scl_reg.fg;
        res_next.diff = scl_reg.diff;
        if (!scl_reg.fg)
        begin
            res_next.shade = '0;
        end
        else if (scl_reg.sat)
        begin
            res_next.shade = dfd_pkg::SHADE_W'(dfd_pkg::SHADE_MAX);
        end
        else
        begin
            res_next.shade = scl_reg.prod[dfd_pkg::SHADE_SHIFT +: dfd_pkg::SHADE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            scl_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmp_rdy)
            begin
                cmp_valid_reg <= in_valid;
            end
            if (scl_rdy)
            begin
                scl_valid_reg <= cmp_valid_reg;
            end
            if (res_rdy)
            begin
                res_valid_reg <= scl_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_rdy && in_valid)
        begin
            cmp_reg <= cmp_next;
        end
        if (scl_rdy && cmp_valid_reg)
        begin
            scl_reg <= scl_next;
        end
        if (res_rdy && scl_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.average_depth    = res_reg.avg;
    assign result.is_foreground    = res_reg.fg;
    assign result.depth_difference = res_reg.diff;
    assign result.difference_shade = res_reg.shade;

endmodule

// ===== rtl/depth_foreground_detect.sv =====
// depth_foreground_detect: top level, threshold register, divider and classifier.
// Depends on dfd_pkg, dfd_if, dfd_divider and dfd_classify.
//
// Usage:
//   pixel  - valid/ready input channel; one transaction per depth pixel carries
//            the depth sum, the sample count and the stored background depth.
//   result - valid/ready output channel; one transaction per pixel with the
//            average depth, the foreground flag, the difference and its shade.
//   cfg_wr_en/cfg_wr_data - writes diff_threshold; change it only while idle.
// Throughput is one pixel per clock while the receiver is ready. From input
// transaction to result valid a pixel passes six divider stages, four quotient
// bits each, set by the 24-bit quotient, then three classify stages (compare,
// reciprocal multiply, output register).
// Reset clears all valid bits and sets diff_threshold to 0.
// When the receiver stalls, results collect in the pipeline; each stage keeps
// taking data while it has a free slot, so the input stays ready until all
// nine stages hold a pixel. Nothing is dropped or repeated.

module depth_foreground_detect
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dfd_pkg::DEPTH_W-1:0] cfg_wr_data,
    dfd_pixel_if.sink                   pixel,
    dfd_result_if.source                result
);

    logic [dfd_pkg::DEPTH_W-1:0] thr_reg;
    logic                        div_valid;
    logic                        div_ready;
    dfd_pkg::quot_t              div_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    dfd_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    dfd_classify u_classify
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .diff_threshold (thr_reg),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .in_data        (div_data),
        .result         (result)
    );

endmodule

// ===== rtl/dfd_checker.sv =====
// dfd_checker: port-level assertions for depth_foreground_detect, attached by bind.
// Depends on dfd_pkg and the top level's ports.

module dfd_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [dfd_pkg::DEPTH_W-1:0] average_depth,
    input  logic                        is_foreground,
    input  logic [dfd_pkg::DEPTH_W-1:0] depth_difference,
    input  logic [dfd_pkg::SHADE_W-1:0] difference_shade
);

    // stalled result transaction keeps its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_depth)
        && $stable(is_foreground) && $stable(depth_difference) && $stable(difference_shade))
        else $error("result changed while stalled");

    // background pixels report no difference and no shade
    a_bg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_foreground |-> depth_difference == '0 && difference_shade == '0)
        else $error("background pixel with nonzero difference");

    // foreground needs a nonzero average and a nonzero difference
    a_fg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_foreground |-> average_depth != '0 && depth_difference != '0)
        else $error("foreground pixel with zero average or difference");

    // shade saturates once the difference reaches the full range
    a_shade_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_foreground
        && depth_difference >= dfd_pkg::DEPTH_W'(dfd_pkg::SHADE_RANGE)
        |-> difference_shade == dfd_pkg::SHADE_W'(dfd_pkg::SHADE_MAX))
        else $error("shade not saturated");

endmodule

bind depth_foreground_detect dfd_checker u_dfd_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .average_depth    (result.average_depth),
    .is_foreground    (result.is_foreground),
    .depth_difference (result.depth_difference),
    .difference_shade (result.difference_shade)
);
